[hw/rtl/pipbt_pkg.sv]
// Package for the point-in-polygon boundary test: coordinate width, payload
// structs, edge record and register index codes. No dependencies.
`timescale 1ns / 1ps

package pipbt_pkg;

    // Coordinate width, signed Q16.8 fixed point
    localparam int COORD_BITS = 24;
    // Edge differences carry one guard bit
    localparam int DIFF_BITS  = COORD_BITS + 1;
    // Exact product of two differences
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    // Default depth of the edge queue
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_TEST_X = 1'b0,
        CFG_TEST_Y = 1'b1
    } t_cfg_idx;

    // One input word: a polygon vertex
    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         last_vertex;
    } t_vertex;

    // One output word: the verdict for a closed polygon
    typedef struct packed {
        logic inside_res;
        logic on_boundary;
    } t_result;

    // One edge test, classified by the front end
    typedef struct packed {
        logic                        straddle;
        logic                        last;
        logic signed [DIFF_BITS-1:0] dx_test;   // test_x - xi
        logic signed [DIFF_BITS-1:0] dy_edge;   // yj - yi
        logic signed [DIFF_BITS-1:0] dx_edge;   // xj - xi
        logic signed [DIFF_BITS-1:0] dy_test;   // test_y - yi
    } t_edge;

endpackage

[hw/rtl/point_in_polygon_boundary_test.sv]
// Top level of the point-in-polygon boundary test: front end, edge queue
// and back end. Uses pipbt_pkg, pipbt_front, pipbt_fifo and pipbt_back.
//
// Usage: vertices of a polygon arrive as words on the input channel
// (i_valid / o_stall, payload i_vertex), the last one flagged by
// last_vertex. The test point sits in two registers written through
// i_cfg_we / i_cfg_idx / i_cfg_data (index 0 test_x, index 1 test_y).
// For each polygon one result word leaves on the output channel
// (o_valid / i_stall, payload o_result): inside_res and on_boundary.
// Throughput: one vertex per cycle while the queue has room; the last
// vertex of a polygon with more than one vertex holds the input until the
// front end has queued the closing edge. The sustained rate is
// set by the front end's one edge record per cycle into the queue.
// Result path after the last vertex: pending closing edge in the front end
// (skipped for a single-vertex polygon), queue write, multiply stage and
// compare into the result register; the result comes later while the queue drains.
// Reset (synchronous, active low) clears the test point, the polygon state,
// the queue and the parities; o_valid is low afterward.
// While the receiver stalls, the result word holds; the back end stops at
// the closing edge, the queue fills and then o_stall rises.
`timescale 1ns / 1ps

module point_in_polygon_boundary_test #(
    parameter int QUEUE_DEPTH = pipbt_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  pipbt_pkg::t_vertex                i_vertex,
    input  logic                              i_cfg_we,
    input  pipbt_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [pipbt_pkg::COORD_BITS-1:0]  i_cfg_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output pipbt_pkg::t_result                o_result
);

    logic             w_push, w_full, w_pop, w_q_valid;
    pipbt_pkg::t_edge w_edge_in, w_edge_out;

    // Accept and classify
    pipbt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_vertex   (i_vertex),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_edge     (w_edge_in)
    );

    // Decouple front and back
    pipbt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_edge  (w_edge_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_edge  (w_edge_out)
    );

    // Multiply, compare, count crossings
    pipbt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_edge  (w_edge_out),
        .o_q_pop   (w_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (o_result)
    );

endmodule

[hw/rtl/pipbt_front.sv]
// Front end: accepts vertices, holds the test point and the first and
// previous vertex, and queues straddling or closing edges. Uses pipbt_pkg.
`timescale 1ns / 1ps

module pipbt_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  pipbt_pkg::t_vertex                    i_vertex,
    input  logic                                  i_cfg_we,
    input  pipbt_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic [pipbt_pkg::COORD_BITS-1:0]      i_cfg_data,
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output pipbt_pkg::t_edge                      o_edge
);

    localparam int CB = pipbt_pkg::COORD_BITS;
    localparam int DB = pipbt_pkg::DIFF_BITS;

    logic signed [CB-1:0] r_test_x, r_test_y;
    logic signed [CB-1:0] r_first_x, r_first_y;
    logic signed [CB-1:0] r_prev_x, r_prev_y;
    logic                 r_open;
    logic                 r_pend;

    logic                 w_accept;
    logic                 w_go;
    logic                 w_last;
    logic signed [CB-1:0] w_xi, w_yi, w_xj, w_yj;
    logic signed [DB-1:0] w_xi_e, w_yi_e, w_xj_e, w_yj_e, w_tx_e, w_ty_e;
    logic                 w_above_i, w_above_j;

    // Hold input while the closing edge waits or the queue is full
    assign o_stall  = r_pend || i_q_full;
    assign w_accept = i_valid && !o_stall;

    // Select the edge to classify this cycle
    always_comb begin
        w_go   = 1'b0;
        w_last = 1'b0;
        w_xi   = i_vertex.vertex_x;
        w_yi   = i_vertex.vertex_y;
        w_xj   = r_prev_x;
        w_yj   = r_prev_y;
        if (r_pend) begin
            // closing edge from the last vertex back to the first
            w_go   = !i_q_full;
            w_last = 1'b1;
            w_xi   = r_first_x;
            w_yi   = r_first_y;
        end else if (w_accept && r_open) begin
            w_go   = 1'b1;
        end else if (w_accept && i_vertex.last_vertex) begin
            // single-vertex polygon: degenerate closing edge
            w_go   = 1'b1;
            w_last = 1'b1;
            w_xj   = i_vertex.vertex_x;
            w_yj   = i_vertex.vertex_y;
        end
    end

    // Classify: straddle test and the four differences
    always_comb begin
        w_xi_e    = {w_xi[CB-1], w_xi};
        w_yi_e    = {w_yi[CB-1], w_yi};
        w_xj_e    = {w_xj[CB-1], w_xj};
        w_yj_e    = {w_yj[CB-1], w_yj};
        w_tx_e    = {r_test_x[CB-1], r_test_x};
        w_ty_e    = {r_test_y[CB-1], r_test_y};
        w_above_i = w_yi > r_test_y;
        w_above_j = w_yj > r_test_y;

        o_edge.straddle = w_above_i != w_above_j;
        o_edge.last     = w_last;
        o_edge.dx_test  = w_tx_e - w_xi_e;
        o_edge.dy_edge  = w_yj_e - w_yi_e;
        o_edge.dx_edge  = w_xj_e - w_xi_e;
        o_edge.dy_test  = w_ty_e - w_yi_e;
    end

    // Drop edges that cannot toggle a parity unless they close the polygon
    assign o_push = w_go && (o_edge.straddle || w_last);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_x <= '0;
            r_test_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pipbt_pkg::CFG_TEST_X: r_test_x <= i_cfg_data;
                pipbt_pkg::CFG_TEST_Y: r_test_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Polygon tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (w_accept) begin
                r_open <= !i_vertex.last_vertex;
                r_pend <= r_open && i_vertex.last_vertex;
            end else if (r_pend && !i_q_full) begin
                r_pend <= 1'b0;
            end
        end
    end

    // Vertex storage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev_x <= i_vertex.vertex_x;
            r_prev_y <= i_vertex.vertex_y;
            if (!r_open) begin
                r_first_x <= i_vertex.vertex_x;
                r_first_y <= i_vertex.vertex_y;
            end
        end
    end

endmodule

[hw/rtl/pipbt_fifo.sv]
// Edge queue between front end and back end: a small register FIFO of
// edge records. Uses pipbt_pkg.
`timescale 1ns / 1ps

module pipbt_fifo #(
    parameter int DEPTH = pipbt_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pipbt_pkg::t_edge  i_edge,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output pipbt_pkg::t_edge  o_edge
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pipbt_pkg::t_edge r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = r_cnt == CW'(DEPTH);
    assign o_valid   = r_cnt != '0;
    assign o_edge    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_edge;
        end
    end

endmodule

[hw/rtl/pipbt_back.sv]
// Back end: multiplies the edge differences, compares the products, keeps
// the crossing parities and drives the result register. Uses pipbt_pkg.
`timescale 1ns / 1ps

module pipbt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  pipbt_pkg::t_edge    i_q_edge,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output pipbt_pkg::t_result  o_result
);

    localparam int PB = pipbt_pkg::PROD_BITS;

    // Multiply stage
    logic                 r_m_valid;
    logic                 r_m_straddle;
    logic                 r_m_last;
    logic                 r_m_dyneg;
    logic signed [PB-1:0] r_p1, r_p2;

    logic                 r_right, r_left;
    logic                 r_out_valid;
    pipbt_pkg::t_result   r_out;

    logic signed [PB-1:0] w_p1, w_p2;
    logic                 w_out_free, w_m_done;
    logic                 w_lt, w_gt;
    logic                 w_right_n, w_left_n;

    // Exact cross products
    assign w_p1 = i_q_edge.dx_test * i_q_edge.dy_edge;
    assign w_p2 = i_q_edge.dx_edge * i_q_edge.dy_test;

    // Retire a stage entry; a closing one waits until its result has a free slot
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_m_done   = r_m_valid && (!r_m_last || w_out_free);
    assign o_q_pop    = i_q_valid && (!r_m_valid || w_m_done);

    // Compare and update the parities
    always_comb begin
        w_lt      = r_p1 < r_p2;
        w_gt      = r_p1 > r_p2;
        w_right_n = r_right;
        w_left_n  = r_left;
        if (r_m_straddle) begin
            if (r_m_dyneg ? w_gt : w_lt) begin
                w_right_n = !r_right;
            end
            if (r_m_dyneg ? w_lt : w_gt) begin
                w_left_n = !r_left;
            end
        end
    end

    // Multiply stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_m_valid <= 1'b1;
        end else if (w_m_done) begin
            r_m_valid <= 1'b0;
        end
    end

    // Multiply stage payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_m_straddle <= i_q_edge.straddle;
            r_m_last     <= i_q_edge.last;
            r_m_dyneg    <= i_q_edge.dy_edge[pipbt_pkg::DIFF_BITS-1];
            r_p1         <= w_p1;
            r_p2         <= w_p2;
        end
    end

    // Parities: clear once a polygon is closed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= 1'b0;
            r_left  <= 1'b0;
        end else if (w_m_done) begin
            r_right <= r_m_last ? 1'b0 : w_right_n;
            r_left  <= r_m_last ? 1'b0 : w_left_n;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_m_done && r_m_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_done && r_m_last) begin
            r_out.inside_res  <= (w_right_n == w_left_n) && w_right_n;
            r_out.on_boundary <= w_right_n != w_left_n;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[hw/rtl/pipbt_checker.sv]
// Port checker for the point-in-polygon boundary test, bound to the top
// level. Uses pipbt_pkg.
`timescale 1ns / 1ps

module pipbt_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  pipbt_pkg::t_vertex                i_vertex,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  pipbt_pkg::t_result                o_result
);

    // A stalled input word stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_vertex))
        else $error("input word dropped or changed while stalled");

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    // A stalled result word does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_result))
        else $error("result word changed while stalled");

    // Inside and on-boundary never both
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.inside_res && o_result.on_boundary))
        else $error("result both inside and on boundary");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

endmodule

bind point_in_polygon_boundary_test pipbt_checker u_pipbt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_vertex   (i_vertex),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_result   (o_result)
);

[verif/point_in_polygon_boundary_test_tb.sv]
// Testbench for point_in_polygon_boundary_test: streams polygons around the
// configured test point and checks each verdict against a local crossing predictor.
// Depends on pipbt_pkg and the point_in_polygon_boundary_test RTL.
`timescale 1ns / 1ps

module point_in_polygon_boundary_test_tb;

    localparam longint COORD_MAX  = 64'sd8388607;
    localparam longint COORD_MIN  = -64'sd8388608;
    localparam int     PHASE_LEN  = 150;
    localparam int     RAND_ITEMS = 1350;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_stall;
    pipbt_pkg::t_vertex   in_word = '0;
    logic      cfg_we = 1'b0;
    pipbt_pkg::t_cfg_idx  cfg_idx = pipbt_pkg::CFG_TEST_X;
    logic [pipbt_pkg::COORD_BITS-1:0] cfg_data = '0;
    logic      o_valid;
    logic      out_stall = 1'b0;
    pipbt_pkg::t_result   o_result;

    // Pending vertex words and expected verdicts
    pipbt_pkg::t_vertex   vertex_q[$];
    pipbt_pkg::t_result   verdict_q[$];

    // Predictor state: test point, polygon start, previous vertex, ray parities
    longint    pt_x = 0, pt_y = 0;
    longint    start_x = 0, start_y = 0;
    longint    prev_vx = 0, prev_vy = 0;
    bit        poly_open = 1'b0;
    bit        right_odd = 1'b0, left_odd = 1'b0;

    int        err_cnt = 0;
    int        tx_gap = 0, tx_mode = 0;
    int        rx_hold = 0, rx_mode = 0, rx_next = 0;
    pipbt_pkg::t_result   want;

    point_in_polygon_boundary_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (o_stall),
        .i_vertex   (in_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_valid    (o_valid),
        .i_stall    (out_stall),
        .o_result   (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Idle length per word: none, short or long, by the side's current mode
    function automatic int pick_gap(int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 2);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    // Toggle a ray parity if the edge j->i straddles the test y
    function automatic void cross_edge(longint xi, longint yi, longint xj, longint yj);
        longint dy;
        longint side;
        if ((yi > pt_y) == (yj > pt_y))
            return;
        dy   = yj - yi;
        side = (pt_x - xi) * dy - (xj - xi) * (pt_y - yi);
        if (dy < 0)
            side = -side;
        if (side < 0)
            right_odd = ~right_odd;
        else if (side > 0)
            left_odd = ~left_odd;
    endfunction

    // Advance the polygon state by one accepted vertex; queue the verdict on close
    function automatic void take_vertex(pipbt_pkg::t_vertex v);
        longint  vx;
        longint  vy;
        pipbt_pkg::t_result r;
        vx = $signed(v.vertex_x);
        vy = $signed(v.vertex_y);
        if (!poly_open) begin
            start_x   = vx;
            start_y   = vy;
            poly_open = 1'b1;
            right_odd = 1'b0;
            left_odd  = 1'b0;
        end else begin
            cross_edge(vx, vy, prev_vx, prev_vy);
        end
        prev_vx = vx;
        prev_vy = vy;
        if (v.last_vertex) begin
            cross_edge(start_x, start_y, vx, vy);
            r.on_boundary = right_odd ^ left_odd;
            r.inside_res  = (right_odd == left_odd) && right_odd;
            verdict_q.push_back(r);
            poly_open = 1'b0;
            right_odd = 1'b0;
            left_odd  = 1'b0;
        end
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint rand_coord();
        longint r;
        r = $urandom_range(0, 16777215);
        if (r > COORD_MAX)
            r -= 16777216;
        return r;
    endfunction

    // Coordinate near c, at a randomly chosen scale
    function automatic longint near_coord(longint c);
        int span;
        case ($urandom_range(0, 3))
            0: span = 1;
            1: span = 16;
            2: span = 1024;
            default: span = 65536;
        endcase
        return c + longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic void push_vertex(longint x, longint y, bit last);
        pipbt_pkg::t_vertex v;
        v.vertex_x    = clamp_coord(x);
        v.vertex_y    = clamp_coord(y);
        v.last_vertex = last;
        vertex_q.push_back(v);
    endfunction

    // Build one random polygon around the test point; returns its vertex count
    function automatic int push_polygon();
        int     n;
        int     i;
        int     m;
        int     k;
        longint dx;
        longint dy;
        if ($urandom_range(0, 19) == 0)
            n = $urandom_range(9, 40);
        else
            n = $urandom_range(1, 8);
        i = 0;
        while (i < n) begin
            case ($urandom_range(0, 9))
                0: push_vertex(rand_coord(), rand_coord(), i == n - 1);
                1: push_vertex(near_coord(pt_x), pt_y, i == n - 1);
                2: push_vertex(pt_x, near_coord(pt_y), i == n - 1);
                3, 4: begin
                    // Two vertices on a line through the test point
                    if (i < n - 1) begin
                        dx = longint'($urandom_range(0, 100)) - 50;
                        dy = longint'($urandom_range(0, 100)) - 50;
                        if (dx == 0 && dy == 0)
                            dy = 1;
                        m = $urandom_range(1, 5);
                        k = m + $urandom_range(1, 5);
                        push_vertex(pt_x - m * dx, pt_y - m * dy, 1'b0);
                        push_vertex(pt_x + (k - m) * dx, pt_y + (k - m) * dy, i + 1 == n - 1);
                        i++;
                    end else begin
                        push_vertex(near_coord(pt_x), near_coord(pt_y), 1'b1);
                    end
                end
                default: push_vertex(near_coord(pt_x), near_coord(pt_y), i == n - 1);
            endcase
            i++;
        end
        return n;
    endfunction

    // Driver: present pending vertex words, idle between them, hold while stalled
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (in_valid && !o_stall)
                take_vertex(in_word);
            if (!in_valid || !o_stall) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end else if (vertex_q.size() > 0) begin
                    in_word  <= vertex_q.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        tx_mode = $urandom_range(0, 2);
                    tx_gap <= pick_gap(tx_mode);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take result words, compare with the oldest verdict, stall at random
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_hold   <= 0;
        end else begin
            rx_next = (rx_hold > 0) ? rx_hold - 1 : 0;
            if (o_valid && !out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("result word with no verdict pending: inside_res %0b on_boundary %0b",
                           o_result.inside_res, o_result.on_boundary);
                    err_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_result.inside_res !== want.inside_res) begin
                        $error("inside_res: expected %0b, got %0b",
                               want.inside_res, o_result.inside_res);
                        err_cnt++;
                    end
                    if (o_result.on_boundary !== want.on_boundary) begin
                        $error("on_boundary: expected %0b, got %0b",
                               want.on_boundary, o_result.on_boundary);
                        err_cnt++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    rx_mode = $urandom_range(0, 2);
                rx_next = pick_gap(rx_mode);
            end
            rx_hold   <= rx_next;
            out_stall <= (rx_next != 0);
        end
    end

    // Write one register; the block is idle whenever this is called
    task automatic write_reg(pipbt_pkg::t_cfg_idx idx, longint val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[pipbt_pkg::COORD_BITS-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == pipbt_pkg::CFG_TEST_X)
            pt_x = $signed(val[pipbt_pkg::COORD_BITS-1:0]);
        else
            pt_y = $signed(val[pipbt_pkg::COORD_BITS-1:0]);
    endtask

    // Wait until every word is in and every verdict is out, then let the pipe settle;
    // sample between edges so the driver's updates for the cycle are visible
    task automatic drain();
        while (vertex_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int     phase;
        int     sent;
        int     in_phase;
        longint tx;
        longint ty;
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed polygons against the reset test point (0,0)
        push_vertex(5, 5, 1'b1);                          // single vertex
        push_vertex(-10, -10, 1'b0);                      // square around the point
        push_vertex(10, -10, 1'b0);
        push_vertex(10, 10, 1'b0);
        push_vertex(-10, 10, 1'b1);
        push_vertex(20, -10, 1'b0);                       // square beside the point
        push_vertex(30, -10, 1'b0);
        push_vertex(30, 10, 1'b0);
        push_vertex(20, 10, 1'b1);
        push_vertex(-10, -10, 1'b0);                      // point on a diagonal edge
        push_vertex(10, 10, 1'b0);
        push_vertex(10, -10, 1'b1);
        push_vertex(-5, -5, 1'b0);                        // segment through the point
        push_vertex(5, 5, 1'b1);
        push_vertex(-5, -5, 1'b0);                        // segment passing beside it
        push_vertex(7, 5, 1'b1);
        push_vertex(COORD_MIN, COORD_MIN, 1'b0);          // full-range triangle
        push_vertex(COORD_MAX, COORD_MIN, 1'b0);
        push_vertex(0, COORD_MAX, 1'b1);
        push_vertex(COORD_MAX, COORD_MAX, 1'b0);          // full-range, point outside
        push_vertex(COORD_MIN, COORD_MAX, 1'b0);
        push_vertex(COORD_MAX, 0, 1'b1);
        push_vertex(-4, 0, 1'b0);                         // vertex level with the point
        push_vertex(0, 0, 1'b0);                          // and a vertex on it
        push_vertex(4, 0, 1'b1);
        drain();

        // Random phases, each under its own test point
        sent  = 0;
        phase = 1;
        while (sent < RAND_ITEMS) begin
            case (phase)
                1: begin tx = COORD_MIN; ty = COORD_MIN; end
                2: begin tx = COORD_MAX; ty = COORD_MAX; end
                3: begin tx = COORD_MIN; ty = COORD_MAX; end
                4: begin tx = COORD_MAX; ty = COORD_MIN; end
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        tx = longint'($urandom_range(0, 2000)) - 1000;
                        ty = longint'($urandom_range(0, 2000)) - 1000;
                    end else begin
                        tx = rand_coord();
                        ty = rand_coord();
                    end
                end
            endcase
            write_reg(pipbt_pkg::CFG_TEST_X, tx);
            write_reg(pipbt_pkg::CFG_TEST_Y, ty);
            in_phase = 0;
            while (in_phase < PHASE_LEN)
                in_phase += push_polygon();
            sent += in_phase;
            drain();
            phase++;
        end

        if (err_cnt == 0)
            $display("point_in_polygon_boundary_test_tb: PASS");
        else
            $display("point_in_polygon_boundary_test_tb: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("point_in_polygon_boundary_test_tb: FAIL");
        $finish;
    end

endmodule
